@@ sv/dnsenc_pkg.sv @@
// Shared types and constants for the DNS name wire-format encoder.
package dnsenc_pkg;

    // Character codes
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_END      = 8'h00;
    localparam logic [7:0] UPPER_BELOW = 8'h40;
    localparam logic [7:0] UPPER_ABOVE = 8'h5B;
    localparam logic [7:0] CASE_BIT    = 8'h20;

    // Widest label length / store address carried between front and back
    localparam int LEN_W = 6;

    // Command queue depth
    localparam int QDEPTH = 2;

    // Work handed from front to back
    typedef struct packed {
        logic [LEN_W-1:0] len;    // label bytes to replay
        logic             close;  // append closing zero, marked last
        logic             err;    // error result only
    } cmd_t;

    // Label store write from the front
    typedef struct packed {
        logic             en;
        logic [LEN_W-1:0] addr;
        logic [7:0]       data;
    } wr_t;

    // Fold ASCII upper case to lower case
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c > UPPER_BELOW && c < UPPER_ABOVE)
        begin
            r = c | CASE_BIT;
        end
        return r;
    endfunction

endpackage

@@ sv/dnsenc_front.sv @@
// Front end: accepts name characters, tracks label/name state, writes the
// label store and queues flush or error commands.
module dnsenc_front #(
    parameter int MAX_LABEL = 62
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         ch,
    input  logic [8:0]         capacity,
    input  logic               q_full,
    output logic               push,
    output dnsenc_pkg::cmd_t   push_cmd,
    output dnsenc_pkg::wr_t    wr,
    input  logic               release_lock
);
    import dnsenc_pkg::*;

    localparam int CW = $clog2(MAX_LABEL + 1);

    logic [CW-1:0] label_count_reg, label_count_next;
    logic [8:0]    name_count_reg, name_count_next;
    logic          at_start_reg, at_start_next;
    logic          discarding_reg, discarding_next;
    logic          lock_reg, lock_next;
    logic          accept;
    logic          over_cap;

    // Stall while the queue is full or the back end still replays the stored label
    assign in_ready = !q_full && !lock_reg;
    assign accept   = in_valid && in_ready;
    assign over_cap = ({1'b0, name_count_reg} + 10'd2) > {1'b0, capacity};

    // Character classification
    always_comb
    begin
        label_count_next = label_count_reg;
        name_count_next  = name_count_reg;
        at_start_next    = at_start_reg;
        discarding_next  = discarding_reg;
        lock_next        = lock_reg;
        push             = 1'b0;
        push_cmd         = '0;
        wr.en            = 1'b0;
        wr.addr          = LEN_W'(label_count_reg);
        wr.data          = fold_case(ch);

        if (release_lock)
        begin
            lock_next = 1'b0;
        end

        if (accept)
        begin
            if (discarding_reg)
            begin
                if (ch == CH_END)
                begin
                    discarding_next  = 1'b0;
                    label_count_next = '0;
                    name_count_next  = '0;
                    at_start_next    = 1'b1;
                end
            end
            else if (at_start_reg && (ch == CH_DOT || ch == CH_END))
            begin
                // leading dot gives an error and drops the rest; leading terminator gives an error and ends the name
                push             = 1'b1;
                push_cmd.err     = 1'b1;
                discarding_next  = (ch == CH_DOT);
                label_count_next = '0;
                name_count_next  = '0;
                at_start_next    = 1'b1;
            end
            else if (ch == CH_END)
            begin
                push             = 1'b1;
                push_cmd.len     = LEN_W'(label_count_reg);
                push_cmd.close   = 1'b1;
                lock_next        = (label_count_reg != '0);
                label_count_next = '0;
                name_count_next  = '0;
                at_start_next    = 1'b1;
            end
            else if (over_cap)
            begin
                push             = 1'b1;
                push_cmd.err     = 1'b1;
                discarding_next  = 1'b1;
                label_count_next = '0;
                name_count_next  = '0;
                at_start_next    = 1'b1;
            end
            else if (ch == CH_DOT)
            begin
                push             = 1'b1;
                push_cmd.len     = LEN_W'(label_count_reg);
                lock_next        = (label_count_reg != '0);
                label_count_next = '0;
                name_count_next  = name_count_reg + 9'd1;
                at_start_next    = 1'b0;
            end
            else if (label_count_reg == CW'(MAX_LABEL))
            begin
                // label too long
                push             = 1'b1;
                push_cmd.err     = 1'b1;
                discarding_next  = 1'b1;
                label_count_next = '0;
                name_count_next  = '0;
                at_start_next    = 1'b1;
            end
            else
            begin
                wr.en            = 1'b1;
                label_count_next = label_count_reg + 1'b1;
                name_count_next  = name_count_reg + 9'd1;
                at_start_next    = 1'b0;
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            label_count_reg <= '0;
            name_count_reg  <= '0;
            at_start_reg    <= 1'b1;
            discarding_reg  <= 1'b0;
            lock_reg        <= 1'b0;
        end
        else
        begin
            label_count_reg <= label_count_next;
            name_count_reg  <= name_count_next;
            at_start_reg    <= at_start_next;
            discarding_reg  <= discarding_next;
            lock_reg        <= lock_next;
        end
    end

endmodule

@@ sv/dnsenc_cmd_fifo.sv @@
// Short command queue between the front and back ends.
module dnsenc_cmd_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  dnsenc_pkg::cmd_t push_cmd,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output dnsenc_pkg::cmd_t head
);
    import dnsenc_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int NW = $clog2(QDEPTH + 1);

    cmd_t          entry_reg [QDEPTH];
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [NW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == NW'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rptr_reg];

    // Pointer and count update
    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PW'(QDEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PW'(QDEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= push_cmd;
        end
    end

endmodule

@@ sv/dnsenc_back.sv @@
// Back end: holds the label memory, replays queued labels as wire bytes
// and drives the output register.
module dnsenc_back #(
    parameter int MAX_LABEL = 62
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    output logic             pop,
    input  dnsenc_pkg::cmd_t cmd,
    input  dnsenc_pkg::wr_t  wr,
    output logic             release_lock,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_byte,
    output logic             last,
    output logic             error
);
    import dnsenc_pkg::*;

    localparam int CW = $clog2(MAX_LABEL + 1);
    localparam int AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_HEAD  = 2'd1;
    localparam logic [1:0] S_DATA  = 2'd2;
    localparam logic [1:0] S_CLOSE = 2'd3;

    logic [7:0]    mem [MAX_LABEL];
    logic [7:0]    rd_data_reg;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] len_reg, len_next;
    logic          close_reg, close_next;
    logic          err_reg, err_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] idx_inc;

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic          last_reg, last_next;
    logic          error_reg, error_next;
    logic          slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign idx_inc   = idx_reg + 1'b1;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;
    assign error     = error_reg;

    // Label memory: one write port from the front, one registered read
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr[AW-1:0]] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Replay sequencer
    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        close_next     = close_reg;
        err_next       = err_reg;
        idx_next       = idx_reg;
        pop            = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        release_lock   = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        error_next     = error_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    len_next   = CW'(cmd.len);
                    close_next = cmd.close;
                    err_next   = cmd.err;
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (err_reg)
                    begin
                        out_byte_next = '0;
                        last_next     = 1'b1;
                        error_next    = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        // length byte
                        out_byte_next = 8'(len_reg);
                        last_next     = 1'b0;
                        error_next    = 1'b0;
                        if (len_reg != '0)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            idx_next   = '0;
                            state_next = S_DATA;
                        end
                        else if (close_reg)
                        begin
                            state_next = S_CLOSE;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            S_DATA:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = rd_data_reg;
                    last_next      = 1'b0;
                    error_next     = 1'b0;
                    if (idx_inc < len_reg)
                    begin
                        // prefetch next label byte
                        rd_en    = 1'b1;
                        rd_addr  = idx_inc[AW-1:0];
                        idx_next = idx_inc;
                    end
                    else
                    begin
                        release_lock = 1'b1;
                        state_next   = close_reg ? S_CLOSE : S_IDLE;
                    end
                end
            end
            S_CLOSE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = '0;
                    last_next      = 1'b1;
                    error_next     = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        len_reg      <= len_next;
        close_reg    <= close_next;
        err_reg      <= err_next;
        idx_reg      <= idx_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
        error_reg    <= error_next;
    end

endmodule

@@ sv/dns_name_label_encoder.sv @@
// Top level of the DNS name wire-format encoder.
//
// Usage: send a dotted name one character per transfer on ch (in_valid /
// in_ready), ended by a zero character. Wire bytes come out on out_byte
// (out_valid / out_ready): per label a length byte and the label bytes,
// upper case folded to lower case, then a closing zero marked last. A
// malformed name, an over-long label or a name over capacity gives one
// byte with last and error set; characters up to the terminator are then
// dropped. capacity is written on the cfg channel while the block is idle.
// Timing: the front end takes a character whenever in_ready is high. A dot
// or the terminator queues a flush; while out_ready stays high, the back
// end sends one byte per cycle out of the label memory (length byte, then
// one read per character). The front end holds in_ready low while a stored
// label is replayed, as both share that memory. A flush goes through the
// command queue and the back-end command registers to the output register.
// Reset: capacity returns to 256, the queue empties, no output is valid.
// A stalled receiver holds the output register; the queue then fills and
// in_ready drops, so nothing is lost.
module dns_name_label_encoder #(
    parameter int MAX_LABEL = 62
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] ch,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [8:0] capacity,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last,
    output logic       error
);
    import dnsenc_pkg::*;

    logic [8:0] capacity_reg;
    logic       q_full;
    logic       q_empty;
    logic       push;
    logic       pop;
    cmd_t       push_cmd;
    cmd_t       head;
    wr_t        wr;
    logic       release_lock;

    // Capacity register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= 9'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            capacity_reg <= capacity;
        end
    end

    dnsenc_front #(
        .MAX_LABEL(MAX_LABEL)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .ch           (ch),
        .capacity     (capacity_reg),
        .q_full       (q_full),
        .push         (push),
        .push_cmd     (push_cmd),
        .wr           (wr),
        .release_lock (release_lock)
    );

    dnsenc_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head     (head)
    );

    dnsenc_back #(
        .MAX_LABEL(MAX_LABEL)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .pop          (pop),
        .cmd          (head),
        .wr           (wr),
        .release_lock (release_lock),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .last         (last),
        .error        (error)
    );

endmodule
